### rtl/sct_pkg.sv
// Shared types, constants and the quarter-wave sine table for the sprite corner transform.
package sct_pkg;

	localparam logic [31:0] SORT_AUTO = 32'hFFFF_FFFF;
	localparam int FULL_STEPS = 5760;
	localparam int QUARTER_STEPS = 1440;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_READ,
		PH_SETUP,
		PH_EMIT
	} phase_t;

	typedef struct packed {
		logic [15:0] texture_id;
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
		logic signed [23:0] quad_width;
		logic signed [23:0] quad_height;
		logic signed [15:0] pivot_x;
		logic signed [15:0] pivot_y;
		logic [1:0] quadrant;
		logic [10:0] rem;
		logic [47:0] uv_rect;
		logic [31:0] rgba;
		logic [31:0] order;
	} sprite_t;

	// Sine of r sixteenths of a degree, r in 0..1440, Q1.14, from a
	// degree-9 polynomial with truncating Q30 arithmetic.
	function automatic logic [14:0] sin_q14(input logic [10:0] r);
		logic [63:0] x, x2, p, s;
		begin
			x = 64'(r) * 64'd1171271;
			x2 = (x * x) >> 30;
			p = (64'd1 << 30) - x2 / 64'd72;
			p = (64'd1 << 30) - ((x2 * p) >> 30) / 64'd42;
			p = (64'd1 << 30) - ((x2 * p) >> 30) / 64'd20;
			p = (64'd1 << 30) - ((x2 * p) >> 30) / 64'd6;
			s = (x * p) >> 30;
			s = (s + 64'd32768) >> 16;
			if (s > 64'd16384) s = 64'd16384;
			return s[14:0];
		end
	endfunction

endpackage

### rtl/sct_sin_rom.sv
// Registered sine table, quarter wave, two read ports.
module sct_sin_rom import sct_pkg::*; (
	input  logic        clk,
	input  logic [10:0] addr_a,
	input  logic [10:0] addr_b,
	output logic [14:0] data_a,
	output logic [14:0] data_b
);
	logic [14:0] rom [0:QUARTER_STEPS];

	always_comb begin
		for (int i = 0; i <= QUARTER_STEPS; i++) rom[i] = sin_q14(11'(i));
	end

	always_ff @(posedge clk) begin
		data_a <= rom[addr_a];
		data_b <= rom[addr_b];
	end
endmodule

### rtl/sct_front.sv
// Front end: accepts sprites, assigns draw order, reduces the angle.
module sct_front import sct_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid,
	output logic               ready,
	input  logic               frame_start,
	input  logic [15:0]        texture_id,
	input  logic signed [23:0] pos_x,
	input  logic signed [23:0] pos_y,
	input  logic signed [23:0] quad_width,
	input  logic signed [23:0] quad_height,
	input  logic signed [15:0] pivot_x,
	input  logic signed [15:0] pivot_y,
	input  logic signed [15:0] angle_deg,
	input  logic [47:0]        uv_rect,
	input  logic [31:0]        rgba,
	input  logic [31:0]        sort_key,
	output logic               q_push,
	output sprite_t            q_data,
	input  logic               q_full
);
	localparam logic [21:0] RECIP_45 = 22'd1457;

	logic [31:0] seq_q;
	logic [31:0] seq_base;
	logic [16:0] a;
	logic [21:0] prod;
	logic [5:0] quo;
	logic [16:0] rr;

	assign ready = !q_full;
	assign q_push = valid && ready;
	assign seq_base = frame_start ? '0 : seq_q;

	always_comb begin
		// Six full turns make every angle positive without changing it modulo a turn.
		a = 17'(angle_deg) + 17'(6 * FULL_STEPS);
		// Quarter turns are 1440 = 32 * 45 steps; the reciprocal of 45 is exact
		// for every value this offset angle can take.
		prod = 22'(a[16:5]) * RECIP_45;
		quo = prod[21:16];
		rr = a - 17'(quo) * 17'(QUARTER_STEPS);
		q_data.texture_id = texture_id;
		q_data.pos_x = pos_x;
		q_data.pos_y = pos_y;
		q_data.quad_width = quad_width;
		q_data.quad_height = quad_height;
		q_data.pivot_x = pivot_x;
		q_data.pivot_y = pivot_y;
		q_data.quadrant = quo[1:0];
		q_data.rem = rr[10:0];
		q_data.uv_rect = uv_rect;
		q_data.rgba = rgba;
		q_data.order = (sort_key == SORT_AUTO) ? seq_base : sort_key;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= '0;
		end else if (q_push) begin
			if (sort_key == SORT_AUTO) seq_q <= seq_base + 32'd1;
			else seq_q <= seq_base;
		end
	end
endmodule

### rtl/sct_fifo.sv
// Two-entry queue between front and back.
module sct_fifo import sct_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  sprite_t push_data,
	output logic    full,
	input  logic    pop,
	output logic    not_empty,
	output sprite_t pop_data
);
	sprite_t mem_q [0:1];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = cnt_q == 2'd2;
	assign not_empty = cnt_q != 2'd0;
	assign pop_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

### rtl/sct_back.sv
// Back end: sine lookup, local corners, rotation and output of four vertices.
module sct_back import sct_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  sprite_t            q_data,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [23:0] vertex_x,
	output logic signed [23:0] vertex_y,
	output logic [11:0]        tex_u,
	output logic [11:0]        tex_v,
	output logic [31:0]        vertex_rgba,
	output logic [15:0]        vertex_texture,
	output logic [31:0]        draw_order,
	output logic [1:0]         corner,
	output logic               last_corner
);
	// Phases: idle, table read, corner setup, emit corners.
	phase_t ph_q, ph_next;
	sprite_t sp_q;
	logic [14:0] sr, cr;
	logic signed [16:0] sn_q, cs_q;
	logic signed [41:0] dx_q, dy_q, wx_q, hy_q;
	logic signed [41:0] lx, ly;
	logic signed [59:0] rx, ry;
	logic signed [60:0] vx, vy;
	logic signed [32:0] fx, fy;
	logic [1:0] k_q;
	logic emit;

	sct_sin_rom u_rom (
		.clk(clk), .addr_a(q_data.rem), .addr_b(11'(QUARTER_STEPS) - q_data.rem),
		.data_a(sr), .data_b(cr)
	);

	always_comb begin
		ph_next = ph_q;
		case (ph_q)
			PH_IDLE: if (q_valid) ph_next = PH_READ;
			PH_READ: ph_next = PH_SETUP;
			PH_SETUP: ph_next = PH_EMIT;
			PH_EMIT: if (emit && k_q == 2'd3) ph_next = PH_IDLE;
			default: ph_next = PH_IDLE;
		endcase
	end

	always_comb begin
		q_pop = 1'b0;
		emit = 1'b0;
		case (ph_q)
			PH_IDLE: q_pop = q_valid;
			PH_EMIT: emit = !out_valid || out_ready;
			default: begin
				q_pop = 1'b0;
				emit = 1'b0;
			end
		endcase
	end

	always_comb begin
		lx = (k_q == 2'd1 || k_q == 2'd2) ? dx_q + wx_q : dx_q;
		ly = (k_q[1]) ? dy_q + hy_q : dy_q;
		rx = 60'(lx) * 60'(cs_q) - 60'(ly) * 60'(sn_q);
		ry = 60'(lx) * 60'(sn_q) + 60'(ly) * 60'(cs_q);
		vx = 61'(rx) + (61'(sp_q.pos_x) <<< 28) + (61'sd1 <<< 27);
		vy = 61'(ry) + (61'(sp_q.pos_y) <<< 28) + (61'sd1 <<< 27);
		fx = 33'(vx >>> 28);
		fy = 33'(vy >>> 28);
	end

	function automatic logic signed [23:0] sat(input logic signed [32:0] v);
		if (v > 33'sd8388607) return 24'sd8388607;
		if (v < -33'sd8388608) return -24'sd8388608;
		return v[23:0];
	endfunction

	always_ff @(posedge clk) begin
		if (q_pop) sp_q <= q_data;
		if (ph_q == PH_READ) begin
			case (sp_q.quadrant)
				2'd0: begin sn_q <= 17'(sr); cs_q <= 17'(cr); end
				2'd1: begin sn_q <= 17'(cr); cs_q <= -17'(sr); end
				2'd2: begin sn_q <= -17'(sr); cs_q <= -17'(cr); end
				default: begin sn_q <= -17'(cr); cs_q <= 17'(sr); end
			endcase
			dx_q <= -(42'(sp_q.quad_width) * (42'sd8192 + 42'(sp_q.pivot_x)));
			dy_q <= -(42'(sp_q.quad_height) * (42'sd8192 + 42'(sp_q.pivot_y)));
			wx_q <= 42'(sp_q.quad_width) <<< 14;
			hy_q <= 42'(sp_q.quad_height) <<< 14;
		end
		if (emit) begin
			vertex_x <= sat(fx);
			vertex_y <= sat(fy);
			tex_u <= (k_q == 2'd1 || k_q == 2'd2) ? sp_q.uv_rect[35:24] : sp_q.uv_rect[11:0];
			tex_v <= k_q[1] ? sp_q.uv_rect[47:36] : sp_q.uv_rect[23:12];
			vertex_rgba <= sp_q.rgba;
			vertex_texture <= sp_q.texture_id;
			draw_order <= sp_q.order;
			corner <= k_q;
			last_corner <= k_q == 2'd3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_IDLE;
			k_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (emit) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			ph_q <= ph_next;
			if (ph_q == PH_SETUP) k_q <= '0;
			else if (emit) k_q <= k_q + 2'd1;
		end
	end
endmodule

### rtl/sprite_corner_transform.sv
// Top level of the sprite corner transform.
//  channel | direction | handshake
//  sprite  | in        | valid / ready, one sprite per word
//  vertex  | out       | out_valid / out_ready, four words per sprite
// A sprite passes through queue pop, sine table read and corner setup, then one vertex
// per cycle while out_ready allows, from the single rotation datapath.
// The front takes new sprites while the two-entry queue has room.
// arst_n clears the sequence counter, queue and control.
// A stalled vertex holds in the output register and stops the back end only.
module sprite_corner_transform import sct_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid,
	output logic               ready,
	input  logic               frame_start,
	input  logic [15:0]        texture_id,
	input  logic signed [23:0] pos_x,
	input  logic signed [23:0] pos_y,
	input  logic signed [23:0] quad_width,
	input  logic signed [23:0] quad_height,
	input  logic signed [15:0] pivot_x,
	input  logic signed [15:0] pivot_y,
	input  logic signed [15:0] angle_deg,
	input  logic [47:0]        uv_rect,
	input  logic [31:0]        rgba,
	input  logic [31:0]        sort_key,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [23:0] vertex_x,
	output logic signed [23:0] vertex_y,
	output logic [11:0]        tex_u,
	output logic [11:0]        tex_v,
	output logic [31:0]        vertex_rgba,
	output logic [15:0]        vertex_texture,
	output logic [31:0]        draw_order,
	output logic [1:0]         corner,
	output logic               last_corner
);
	logic q_push, q_full, q_pop, q_ne;
	sprite_t q_in, q_out;

	sct_front u_front (
		.clk(clk), .arst_n(arst_n), .valid(valid), .ready(ready),
		.frame_start(frame_start), .texture_id(texture_id), .pos_x(pos_x), .pos_y(pos_y),
		.quad_width(quad_width), .quad_height(quad_height), .pivot_x(pivot_x),
		.pivot_y(pivot_y), .angle_deg(angle_deg), .uv_rect(uv_rect), .rgba(rgba),
		.sort_key(sort_key), .q_push(q_push), .q_data(q_in), .q_full(q_full)
	);

	sct_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(q_push), .push_data(q_in), .full(q_full),
		.pop(q_pop), .not_empty(q_ne), .pop_data(q_out)
	);

	sct_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_ne), .q_data(q_out), .q_pop(q_pop),
		.out_valid(out_valid), .out_ready(out_ready), .vertex_x(vertex_x),
		.vertex_y(vertex_y), .tex_u(tex_u), .tex_v(tex_v), .vertex_rgba(vertex_rgba),
		.vertex_texture(vertex_texture), .draw_order(draw_order), .corner(corner),
		.last_corner(last_corner)
	);

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_corner == (corner == 2'd3)))
		else $error("last_corner does not match corner");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !q_push)
		else $error("push into full queue");
	a_corner_step: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && corner != 2'd3) |=> out_valid && corner == $past(corner) + 2'd1
		|| !out_valid)
		else $error("corner sequence broken");
endmodule
